FILE: rtl/dmxr_pkg.sv
// Package for the DMX512 frame receiver: sizes, codes, queue word types.
// Depends on nothing; every other file in rtl but dmxr_ram uses it by scoped names.
package dmxr_pkg;

	// Slot store size, the address width that follows from it, and the field widths.
	localparam int SLOTS      = 512;
	localparam int SLOT_AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IDX_W      = 9;
	localparam int COUNT_W    = 10;
	localparam int TIME_W     = 32;
	localparam int BYTE_W     = 8;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	// Action codes on the event channel.
	localparam logic [1:0] ACT_BYTE = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	// Receiver state as reported on the result channel.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BREAK = 2'd1;
	localparam logic [1:0] ST_DATA  = 2'd2;

	localparam logic [BYTE_W-1:0] START_CODE = 8'h00;

	// Receiver state machine, one-hot.
	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_BREAK = 3'b010,
		MODE_DATA  = 3'b100
	} mode_t;

	// Slot store operation carried with each queued word.
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} mem_op_t;

	// Status fields already settled by the front.
	typedef struct packed {
		logic [1:0]         rx_state;
		logic               packet_done;
		logic [COUNT_W-1:0] slots_in_packet;
		logic [TIME_W-1:0]  slot_gap_us;
	} status_t;

	// One word of the front-to-back queue.
	typedef struct packed {
		mem_op_t            op;
		logic [IDX_W-1:0]   addr;
		logic [BYTE_W-1:0]  wdata;
		status_t            status;
	} qword_t;

	// Map the one-hot state onto the reported state code.
	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		unique case (m)
			MODE_BREAK: c = ST_BREAK;
			MODE_DATA:  c = ST_DATA;
			default:    c = ST_IDLE;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/dmxr_if.sv
// Handshake interfaces for the event channel and the result channel.
// Depends on dmxr_pkg for the field widths.
interface dmxr_evt_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  action;
	logic                        break_seen;
	logic [dmxr_pkg::BYTE_W-1:0] rx_byte;
	logic [dmxr_pkg::TIME_W-1:0] time_us;
	logic [dmxr_pkg::IDX_W-1:0]  slot_index;

	modport source(output valid, action, break_seen, rx_byte, time_us, slot_index,
		input ready);
	modport sink(input valid, action, break_seen, rx_byte, time_us, slot_index,
		output ready);
endinterface

interface dmxr_res_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   rx_state;
	logic                         packet_done;
	logic [dmxr_pkg::COUNT_W-1:0] slots_in_packet;
	logic [dmxr_pkg::TIME_W-1:0]  slot_gap_us;
	logic [dmxr_pkg::BYTE_W-1:0]  read_value;

	modport source(output valid, rx_state, packet_done, slots_in_packet, slot_gap_us,
		read_value, input ready);
	modport sink(input valid, rx_state, packet_done, slots_in_packet, slot_gap_us,
		read_value, output ready);
endinterface

FILE: rtl/dmxr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the slot store.
module dmxr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, and a read port whose data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/dmxr_front.sv
// Front of the receiver: accepts events, runs the frame state machine and
// queues one word per event. Depends on dmxr_pkg and dmxr_if.
module dmxr_front (
	input  logic             clk,
	input  logic             arst_n,
	dmxr_evt_if.sink         evt,
	input  logic             q_full,
	output logic             q_push,
	output dmxr_pkg::qword_t q_word
);

	dmxr_pkg::mode_t                    mode_q, mode_nxt;
	logic [dmxr_pkg::COUNT_W-1:0]       count_q, count_nxt, count_inc;
	logic [dmxr_pkg::TIME_W-1:0]        last_time_q, last_time_nxt;
	logic [dmxr_pkg::TIME_W-1:0]        gap_q, gap_nxt, gap_meas, limit;
	logic [dmxr_pkg::COUNT_W-1:0]       frame_q, frame_nxt;
	logic                               done;
	dmxr_pkg::mem_op_t                  op;
	logic [dmxr_pkg::IDX_W-1:0]         addr;
	logic                               accept;

	assign evt.ready = !q_full;
	assign accept    = evt.valid && evt.ready;

	assign count_inc = count_q + dmxr_pkg::COUNT_W'(1);
	assign gap_meas  = evt.time_us - last_time_q;
	assign limit     = last_time_q + gap_q;

	// Next state of the receiver for the word on the channel.
	always_comb begin
		mode_nxt      = mode_q;
		count_nxt     = count_q;
		last_time_nxt = last_time_q;
		gap_nxt       = gap_q;
		frame_nxt     = frame_q;
		done          = 1'b0;
		op            = dmxr_pkg::OP_NONE;
		addr          = evt.slot_index;
		unique case (evt.action)
			dmxr_pkg::ACT_BYTE: begin
				last_time_nxt = evt.time_us;
				priority if (evt.break_seen) begin
					mode_nxt = dmxr_pkg::MODE_BREAK;
				end else if (mode_q == dmxr_pkg::MODE_BREAK) begin
					if (evt.rx_byte == dmxr_pkg::START_CODE) begin
						mode_nxt  = dmxr_pkg::MODE_DATA;
						count_nxt = '0;
						gap_nxt   = gap_meas;
					end else begin
						mode_nxt = dmxr_pkg::MODE_IDLE;
					end
				end else if (mode_q == dmxr_pkg::MODE_DATA) begin
					// Store the slot; the count is always below the store size here.
					op        = dmxr_pkg::OP_WRITE;
					addr      = count_q[dmxr_pkg::IDX_W-1:0];
					count_nxt = count_inc;
					gap_nxt   = gap_meas;
					if (count_inc == dmxr_pkg::COUNT_W'(dmxr_pkg::SLOTS)) begin
						mode_nxt  = dmxr_pkg::MODE_IDLE;
						frame_nxt = dmxr_pkg::COUNT_W'(dmxr_pkg::SLOTS);
						done      = 1'b1;
					end
				end else begin
					mode_nxt = mode_q;
				end
			end
			dmxr_pkg::ACT_TICK: begin
				// Silence longer than the last gap closes the frame.
				if (mode_q == dmxr_pkg::MODE_DATA && evt.time_us > limit) begin
					mode_nxt  = dmxr_pkg::MODE_IDLE;
					frame_nxt = count_q;
					done      = 1'b1;
				end
			end
			dmxr_pkg::ACT_READ: begin
				op = dmxr_pkg::OP_READ;
			end
			default: begin
				op = dmxr_pkg::OP_NONE;
			end
		endcase
	end

	// Queue word for the back.
	always_comb begin
		q_word.op                     = op;
		q_word.addr                   = addr;
		q_word.wdata                  = evt.rx_byte;
		q_word.status.rx_state        = dmxr_pkg::mode_code(mode_nxt);
		q_word.status.packet_done     = done;
		q_word.status.slots_in_packet = frame_nxt;
		q_word.status.slot_gap_us     = gap_nxt;
	end
	assign q_push = accept;

	// Receiver state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= dmxr_pkg::MODE_IDLE;
			count_q     <= '0;
			last_time_q <= '0;
			gap_q       <= '0;
			frame_q     <= '0;
		end else if (accept) begin
			mode_q      <= mode_nxt;
			count_q     <= count_nxt;
			last_time_q <= last_time_nxt;
			gap_q       <= gap_nxt;
			frame_q     <= frame_nxt;
		end
	end

endmodule

FILE: rtl/dmxr_queue.sv
// Short first-in first-out queue of words between the front and the back.
// Depends on dmxr_pkg.
module dmxr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dmxr_pkg::qword_t push_word,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output dmxr_pkg::qword_t head
);

	dmxr_pkg::qword_t                 entry_q [dmxr_pkg::QDEPTH];
	logic [dmxr_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [dmxr_pkg::QCNT_W-1:0]      count_q;

	assign full      = count_q == dmxr_pkg::QCNT_W'(dmxr_pkg::QDEPTH);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_ptr_q];

	// Storage; no reset needed on the words themselves.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + dmxr_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + dmxr_pkg::QPTR_W'(1);
			end
			priority if (push && !pop) begin
				count_q <= count_q + dmxr_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - dmxr_pkg::QCNT_W'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

endmodule

FILE: rtl/dmxr_back.sv
// Back of the receiver: carries out slot store writes and reads and holds
// the result word. Depends on dmxr_pkg, dmxr_if and dmxr_ram.
module dmxr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  dmxr_pkg::qword_t q_head,
	output logic             q_pop,
	dmxr_res_if.source       res
);

	logic                           out_valid_q;
	dmxr_pkg::status_t              status_s2;
	logic                           hit_s2;
	logic [dmxr_pkg::COUNT_W-1:0]   fill_q;
	logic [dmxr_pkg::COUNT_W-1:0]   addr_ext;
	logic                           do_write, do_read;
	logic [dmxr_pkg::BYTE_W-1:0]    rdata;

	// Take a word whenever the result register is free or being emptied.
	assign q_pop    = q_not_empty && (!out_valid_q || res.ready);
	assign addr_ext = dmxr_pkg::COUNT_W'(q_head.addr);
	assign do_write = q_pop && q_head.op == dmxr_pkg::OP_WRITE;
	// Slots are written from zero upwards, so anything at or above the fill
	// mark has never been written and still reads as zero.
	assign do_read  = q_pop && q_head.op == dmxr_pkg::OP_READ && addr_ext < fill_q;

	dmxr_ram #(
		.WIDTH(dmxr_pkg::BYTE_W),
		.DEPTH(dmxr_pkg::SLOTS)
	) u_store (
		.clk  (clk),
		.we   (do_write),
		.waddr(q_head.addr[dmxr_pkg::SLOT_AW-1:0]),
		.wdata(q_head.wdata),
		.re   (do_read),
		.raddr(q_head.addr[dmxr_pkg::SLOT_AW-1:0]),
		.rdata(rdata)
	);

	// Fill mark of the slot store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (do_write && addr_ext >= fill_q) begin
			fill_q <= addr_ext + dmxr_pkg::COUNT_W'(1);
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, aligned with the registered read data.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_s2 <= q_head.status;
			hit_s2    <= do_read;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.rx_state        = status_s2.rx_state;
	assign res.packet_done     = status_s2.packet_done;
	assign res.slots_in_packet = status_s2.slots_in_packet;
	assign res.slot_gap_us     = status_s2.slot_gap_us;
	assign res.read_value      = hit_s2 ? rdata : '0;

endmodule

FILE: rtl/dmx512_frame_receiver.sv
// DMX512 frame receiver, top level. An accepted word is written into the queue
// and then taken into the result register once that register is free or being emptied.
// Throughput: one word per cycle while the queue has room and the result side is ready.
// Reset: arst_n clears state, the queue and the slot store fill mark at once;
// the slot store needs no clearing pass and the block is ready right after.
// Depends on dmxr_pkg, dmxr_if, dmxr_front, dmxr_queue and dmxr_back.
module dmx512_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	dmxr_evt_if.sink   evt,
	dmxr_res_if.source res
);

	logic             q_push, q_full, q_pop, q_not_empty;
	dmxr_pkg::qword_t q_word, q_head;

	dmxr_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.evt   (evt),
		.q_full(q_full),
		.q_push(q_push),
		.q_word(q_word)
	);

	dmxr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_word(q_word),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	dmxr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.res        (res)
	);

endmodule

FILE: rtl/dmxr_checker.sv
// Checks on the result port of the DMX512 frame receiver, and its bind.
// Depends on dmxr_pkg; attached to dmx512_frame_receiver.
module dmxr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [1:0]                   res_rx_state,
	input logic                         res_packet_done,
	input logic [dmxr_pkg::COUNT_W-1:0] res_slots_in_packet,
	input logic [dmxr_pkg::TIME_W-1:0]  res_slot_gap_us,
	input logic [dmxr_pkg::BYTE_W-1:0]  res_read_value
);

	// A stalled result word stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_rx_state)
		&& $stable(res_packet_done) && $stable(res_slots_in_packet)
		&& $stable(res_slot_gap_us) && $stable(res_read_value))
		else $error("result word changed while stalled");

	// A finished frame always leaves the receiver idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_packet_done |-> res_rx_state == dmxr_pkg::ST_IDLE)
		else $error("frame end reported outside idle");

	// Only a read returns slot data, and a read never ends a frame.
	a_read_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_read_value != '0 |-> !res_packet_done)
		else $error("slot data reported with a frame end");

	// The frame length never exceeds the store.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_slots_in_packet <= dmxr_pkg::COUNT_W'(dmxr_pkg::SLOTS))
		else $error("frame length beyond slot store size");

endmodule

bind dmx512_frame_receiver dmxr_checker u_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_rx_state       (res.rx_state),
	.res_packet_done    (res.packet_done),
	.res_slots_in_packet(res.slots_in_packet),
	.res_slot_gap_us    (res.slot_gap_us),
	.res_read_value     (res.read_value)
);

FILE: tb/dmx512_frame_receiver_tb.sv
// Self-checking testbench for the DMX512 frame receiver: a directed table, then
// random frames, reads and noise, checked word by word against a behavioural predictor.
// Depends on dmxr_pkg, dmxr_if and the dmx512_frame_receiver top level.
`timescale 1ns / 100ps

module dmx512_frame_receiver_tb;

	// Sizes and codes taken from the package.
	localparam int SLOTS   = dmxr_pkg::SLOTS;
	localparam int SLOT_AW = dmxr_pkg::SLOT_AW;
	localparam int IDX_W   = dmxr_pkg::IDX_W;
	localparam int COUNT_W = dmxr_pkg::COUNT_W;
	localparam int TIME_W  = dmxr_pkg::TIME_W;
	localparam int BYTE_W  = dmxr_pkg::BYTE_W;
	localparam logic [1:0] ACT_BYTE = dmxr_pkg::ACT_BYTE;
	localparam logic [1:0] ACT_TICK = dmxr_pkg::ACT_TICK;
	localparam logic [1:0] ACT_READ = dmxr_pkg::ACT_READ;
	localparam logic [1:0] ST_IDLE  = dmxr_pkg::ST_IDLE;
	localparam logic [1:0] ST_BREAK = dmxr_pkg::ST_BREAK;
	localparam logic [1:0] ST_DATA  = dmxr_pkg::ST_DATA;
	localparam logic [BYTE_W-1:0] START_CODE = dmxr_pkg::START_CODE;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 900;
	localparam int MAX_REPORTS = 10;
	localparam int SCRIPT_LEN = 24;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [1:0]        action;
		logic              break_seen;
		logic [BYTE_W-1:0] rx_byte;
		logic [TIME_W-1:0] time_us;
		logic [IDX_W-1:0]  slot_index;
	} dmx_event_t;

	typedef struct packed {
		logic [1:0]         rx_state;
		logic               packet_done;
		logic [COUNT_W-1:0] slots_in_packet;
		logic [TIME_W-1:0]  slot_gap_us;
		logic [BYTE_W-1:0]  read_value;
	} dmx_status_t;

	typedef struct packed {
		logic        use_pin;
		dmx_status_t want;
	} pin_t;

	typedef struct packed {
		dmx_event_t  ev;
		logic        use_pin;
		dmx_status_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dmxr_evt_if evt_ch();
	dmxr_res_if res_ch();

	dmx512_frame_receiver uut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch)
	);

	always #5 clk = ~clk;

	// Predictor state: receiver mode, event times, gap and the slot shadow.
	logic [1:0]         link_mode;
	logic [COUNT_W-1:0] frame_fill;
	logic [TIME_W-1:0]  evt_time_now;
	logic [TIME_W-1:0]  evt_time_prev;
	logic [TIME_W-1:0]  measured_gap;
	logic [COUNT_W-1:0] frame_slots;
	logic [BYTE_W-1:0]  slot_shadow [SLOTS];

	dmx_status_t awaited_status [$];
	pin_t        pin_q [$];
	int          fault_count = 0;
	int          cycle_count = 0;
	int          words_sent = 0;
	int          src_calm = 0;
	int          snk_calm = 0;

	// Directed stimulus. Rows with use_pin set carry a result read straight off
	// the behaviour; the others are left to the predictor.
	script_row_t script [SCRIPT_LEN] = '{
		'{'{ACT_READ, 1'b0, 8'h00, 32'd0, 9'd0}, 1'b1,
			'{ST_IDLE, 1'b0, 10'd0, 32'd0, 8'h00}},
		'{'{ACT_TICK, 1'b0, 8'h00, 32'hFFFF_FFFF, 9'd0}, 1'b1,
			'{ST_IDLE, 1'b0, 10'd0, 32'd0, 8'h00}},
		'{'{ACT_SPARE, 1'b1, 8'hFF, 32'hFFFF_FFFF, 9'd511}, 1'b1,
			'{ST_IDLE, 1'b0, 10'd0, 32'd0, 8'h00}},
		'{'{ACT_BYTE, 1'b0, 8'h37, 32'd50, 9'd0}, 1'b1,
			'{ST_IDLE, 1'b0, 10'd0, 32'd0, 8'h00}},
		'{'{ACT_BYTE, 1'b1, 8'h00, 32'd100, 9'd0}, 1'b1,
			'{ST_BREAK, 1'b0, 10'd0, 32'd0, 8'h00}},
		'{'{ACT_BYTE, 1'b0, START_CODE, 32'd144, 9'd0}, 1'b1,
			'{ST_DATA, 1'b0, 10'd0, 32'd44, 8'h00}},
		'{'{ACT_BYTE, 1'b0, 8'hFF, 32'd188, 9'd0}, 1'b1,
			'{ST_DATA, 1'b0, 10'd0, 32'd44, 8'h00}},
		'{'{ACT_BYTE, 1'b0, 8'h00, 32'd232, 9'd0}, 1'b1,
			'{ST_DATA, 1'b0, 10'd0, 32'd44, 8'h00}},
		'{'{ACT_TICK, 1'b0, 8'h00, 32'd276, 9'd0}, 1'b1,
			'{ST_DATA, 1'b0, 10'd0, 32'd44, 8'h00}},
		'{'{ACT_TICK, 1'b0, 8'h00, 32'd277, 9'd0}, 1'b1,
			'{ST_IDLE, 1'b1, 10'd2, 32'd44, 8'h00}},
		'{'{ACT_READ, 1'b0, 8'h00, 32'd0, 9'd0}, 1'b1,
			'{ST_IDLE, 1'b0, 10'd2, 32'd44, 8'hFF}},
		'{'{ACT_READ, 1'b1, 8'hFF, 32'hFFFF_FFFF, 9'd1}, 1'b1,
			'{ST_IDLE, 1'b0, 10'd2, 32'd44, 8'h00}},
		'{'{ACT_READ, 1'b0, 8'h00, 32'd0, 9'd511}, 1'b1,
			'{ST_IDLE, 1'b0, 10'd2, 32'd44, 8'h00}},
		'{'{ACT_TICK, 1'b0, 8'h00, 32'd1000, 9'd0}, 1'b1,
			'{ST_IDLE, 1'b0, 10'd2, 32'd44, 8'h00}},
		'{'{ACT_BYTE, 1'b1, 8'hC3, 32'd2000, 9'd0}, 1'b1,
			'{ST_BREAK, 1'b0, 10'd2, 32'd44, 8'h00}},
		'{'{ACT_BYTE, 1'b0, 8'h5A, 32'd2010, 9'd0}, 1'b1,
			'{ST_IDLE, 1'b0, 10'd2, 32'd44, 8'h00}},
		'{'{ACT_BYTE, 1'b1, 8'h00, 32'hFFFF_FFFF, 9'd0}, 1'b1,
			'{ST_BREAK, 1'b0, 10'd2, 32'd44, 8'h00}},
		'{'{ACT_BYTE, 1'b0, START_CODE, 32'd0, 9'd0}, 1'b1,
			'{ST_DATA, 1'b0, 10'd2, 32'd1, 8'h00}},
		'{'{ACT_BYTE, 1'b0, 8'hA5, 32'd1, 9'd0}, 1'b1,
			'{ST_DATA, 1'b0, 10'd2, 32'd1, 8'h00}},
		'{'{ACT_BYTE, 1'b1, 8'h11, 32'd9, 9'd0}, 1'b1,
			'{ST_BREAK, 1'b0, 10'd2, 32'd1, 8'h00}},
		'{'{ACT_BYTE, 1'b0, START_CODE, 32'hFFFF_FFE0, 9'd0}, 1'b0, '0},
		'{'{ACT_BYTE, 1'b0, 8'h3C, 32'hFFFF_FFF0, 9'd0}, 1'b1,
			'{ST_DATA, 1'b0, 10'd2, 32'd16, 8'h00}},
		'{'{ACT_TICK, 1'b0, 8'h00, 32'd5, 9'd0}, 1'b1,
			'{ST_IDLE, 1'b1, 10'd1, 32'd16, 8'h00}},
		'{'{ACT_READ, 1'b0, 8'h00, 32'd0, 9'd0}, 1'b0, '0}
	};

	// Idle length for one word, with occasional runs of back-to-back words.
	function automatic int draw_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// Time between byte events: mostly short, sometimes long, now and then huge.
	function automatic logic [TIME_W-1:0] draw_step();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return $urandom_range(1, 80);
		else if (pick < 9)
			return $urandom_range(81, 5000);
		return $urandom;
	endfunction

	// Random field values at the width of their fields.
	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [IDX_W-1:0] rand_idx();
		return IDX_W'($urandom_range(0, SLOTS - 1));
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// Frame tracking: works out the status word that one event produces.
	task automatic track_event(input dmx_event_t ev, output dmx_status_t st);
		logic [TIME_W-1:0] limit;
		st = '0;
		case (ev.action)
			ACT_BYTE: begin
				evt_time_now = ev.time_us;
				if (ev.break_seen) begin
					link_mode = ST_BREAK;
				end else if (link_mode == ST_BREAK) begin
					if (ev.rx_byte == START_CODE) begin
						link_mode = ST_DATA;
						frame_fill = '0;
						measured_gap = evt_time_now - evt_time_prev;
					end else begin
						link_mode = ST_IDLE;
					end
				end else if (link_mode == ST_DATA) begin
					if (frame_fill < COUNT_W'(SLOTS))
						slot_shadow[frame_fill[SLOT_AW-1:0]] = ev.rx_byte;
					frame_fill = frame_fill + 1'b1;
					measured_gap = evt_time_now - evt_time_prev;
					if (frame_fill >= COUNT_W'(SLOTS)) begin
						link_mode = ST_IDLE;
						frame_slots = COUNT_W'(SLOTS);
						st.packet_done = 1'b1;
					end
				end
				evt_time_prev = evt_time_now;
			end
			ACT_TICK: begin
				// Plain unsigned compare; the sum wraps and nothing corrects it.
				limit = evt_time_now + measured_gap;
				if (link_mode == ST_DATA && ev.time_us > limit) begin
					link_mode = ST_IDLE;
					frame_slots = frame_fill;
					st.packet_done = 1'b1;
				end
			end
			ACT_READ: begin
				if (COUNT_W'(ev.slot_index) < COUNT_W'(SLOTS))
					st.read_value = slot_shadow[ev.slot_index];
			end
			default: begin
			end
		endcase
		st.rx_state = link_mode;
		st.slots_in_packet = frame_slots;
		st.slot_gap_us = measured_gap;
	endtask

	// Compare one result word with the oldest expectation.
	task automatic check_status(input dmx_status_t want, input dmx_status_t got);
		if (got.rx_state !== want.rx_state || got.packet_done !== want.packet_done ||
			got.slots_in_packet !== want.slots_in_packet ||
			got.slot_gap_us !== want.slot_gap_us || got.read_value !== want.read_value) begin
			fault_count++;
			if (fault_count <= MAX_REPORTS)
				$display("mismatch at %0t: expected state %0d done %0d slots %0d gap %0d rd %0h,",
					$realtime, want.rx_state, want.packet_done, want.slots_in_packet,
					want.slot_gap_us, want.read_value,
					" got state %0d done %0d slots %0d gap %0d rd %0h",
					got.rx_state, got.packet_done, got.slots_in_packet,
					got.slot_gap_us, got.read_value);
		end
	endtask

	// Send one word after a random idle stretch and wait for it to be taken.
	task automatic send_word(input dmx_event_t ev, input logic pin, input dmx_status_t want);
		int gap;
		gap = draw_gap(src_calm);
		pin_q.push_back('{pin, want});
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid      <= 1'b1;
		evt_ch.action     <= ev.action;
		evt_ch.break_seen <= ev.break_seen;
		evt_ch.rx_byte    <= ev.rx_byte;
		evt_ch.time_us    <= ev.time_us;
		evt_ch.slot_index <= ev.slot_index;
		@(posedge clk);
		while (!evt_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	// Random filler goes into the fields that an action does not look at.
	task automatic send_byte(input logic brk, input logic [BYTE_W-1:0] b,
		input logic [TIME_W-1:0] t);
		dmx_event_t ev;
		ev.action = ACT_BYTE;
		ev.break_seen = brk;
		ev.rx_byte = b;
		ev.time_us = t;
		ev.slot_index = rand_idx();
		send_word(ev, 1'b0, '0);
	endtask

	task automatic send_tick(input logic [TIME_W-1:0] t);
		dmx_event_t ev;
		ev.action = ACT_TICK;
		ev.break_seen = rand_bit();
		ev.rx_byte = rand_byte();
		ev.time_us = t;
		ev.slot_index = rand_idx();
		send_word(ev, 1'b0, '0);
	endtask

	task automatic send_read(input logic [IDX_W-1:0] idx);
		dmx_event_t ev;
		ev.action = ACT_READ;
		ev.break_seen = rand_bit();
		ev.rx_byte = rand_byte();
		ev.time_us = $urandom;
		ev.slot_index = idx;
		send_word(ev, 1'b0, '0);
	endtask

	// The scoreboard records the last accepted word at the same edge, so wait for
	// the next edge before judging the queue of expectations.
	task automatic wait_for_results();
		@(posedge clk);
		while (awaited_status.size() != 0) @(posedge clk);
	endtask

	// Predictor reset.
	initial begin : shadow_reset
		link_mode = ST_IDLE;
		frame_fill = '0;
		evt_time_now = '0;
		evt_time_prev = '0;
		measured_gap = '0;
		frame_slots = '0;
		for (int i = 0; i < SLOTS; i++)
			slot_shadow[i] = '0;
	end

	// Result side: random stalls between words.
	initial begin : result_sink
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_gap(snk_calm);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	// Scoreboard: predicts on every accepted event word, checks every result word.
	always @(posedge clk) begin : scoreboard
		dmx_event_t  ev;
		dmx_status_t want;
		dmx_status_t got;
		pin_t        pin;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dmx512_frame_receiver_tb: errors");
			$finish;
		end else if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready) begin
				ev = '{evt_ch.action, evt_ch.break_seen, evt_ch.rx_byte,
					evt_ch.time_us, evt_ch.slot_index};
				track_event(ev, want);
				pin = pin_q.pop_front();
				if (pin.use_pin)
					want = pin.want;
				awaited_status.push_back(want);
			end
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.rx_state, res_ch.packet_done, res_ch.slots_in_packet,
					res_ch.slot_gap_us, res_ch.read_value};
				if (awaited_status.size() == 0) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("unexpected result word at %0t", $realtime);
				end else begin
					check_status(awaited_status.pop_front(), got);
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		dmx_event_t        ev;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] g;
		logic              full_frame_sent;
		int                pick;
		int                frame_len;
		int                ending;

		full_frame_sent = 1'b0;
		evt_ch.valid      <= 1'b0;
		evt_ch.action     <= ACT_BYTE;
		evt_ch.break_seen <= 1'b0;
		evt_ch.rx_byte    <= '0;
		evt_ch.time_us    <= '0;
		evt_ch.slot_index <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (int i = 0; i < SCRIPT_LEN; i++)
			send_word(script[i].ev, script[i].use_pin, script[i].want);
		evt_ch.valid <= 1'b0;
		wait_for_results();

		// Random part: mostly well-formed frames, the rest reads, broken
		// sequences and noise.
		while (words_sent < SCRIPT_LEN + RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (!full_frame_sent && words_sent > 300) begin
				// One frame that fills the whole store, two reads, then a pause.
				full_frame_sent = 1'b1;
				t = $urandom;
				send_byte(1'b1, rand_byte(), t);
				t = t + draw_step();
				send_byte(1'b0, START_CODE, t);
				for (int i = 0; i < SLOTS; i++) begin
					t = t + $urandom_range(1, 60);
					send_byte(1'b0, rand_byte(), t);
				end
				send_read(IDX_W'(SLOTS - 1));
				send_read(rand_idx());
				evt_ch.valid <= 1'b0;
				wait_for_results();
			end else if (pick < 60) begin
				// Well-formed frame with random content and occasional early ticks.
				frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
					: $urandom_range(1, 24);
				t = $urandom;
				send_byte(1'b1, rand_byte(), t);
				g = draw_step();
				t = t + g;
				send_byte(1'b0, START_CODE, t);
				for (int i = 0; i < frame_len; i++) begin
					g = draw_step();
					t = t + g;
					case ($urandom_range(0, 3))
						0: send_byte(1'b0, 8'h00, t);
						1: send_byte(1'b0, 8'hFF, t);
						default: send_byte(1'b0, rand_byte(), t);
					endcase
					if ($urandom_range(0, 6) == 0)
						send_tick(t + $urandom_range(0, g));
					if ($urandom_range(0, 9) == 0)
						send_read(rand_idx());
				end
				ending = $urandom_range(0, 9);
				if (ending < 8)
					send_tick(t + g + 1 + $urandom_range(0, 50));
				else if (ending == 8)
					send_byte(1'b1, rand_byte(), t + draw_step());
				send_read(IDX_W'($urandom_range(0, frame_len - 1)));
			end else if (pick < 75) begin
				send_read(rand_idx());
			end else if (pick < 85) begin
				// Broken sequences: bad start code, start code without a break,
				// or a second break in a row.
				t = $urandom;
				case ($urandom_range(0, 2))
					0: begin
						send_byte(1'b1, rand_byte(), t);
						send_byte(1'b0, BYTE_W'($urandom_range(1, 255)), t + draw_step());
					end
					1: send_byte(1'b0, START_CODE, t);
					default: begin
						send_byte(1'b1, rand_byte(), t);
						send_byte(1'b1, START_CODE, t + draw_step());
					end
				endcase
			end else begin
				// Noise: any field, any action code.
				ev.action = 2'($urandom_range(0, 3));
				ev.break_seen = rand_bit();
				ev.rx_byte = rand_byte();
				ev.time_us = $urandom;
				ev.slot_index = rand_idx();
				send_word(ev, 1'b0, '0);
			end
		end
		evt_ch.valid <= 1'b0;

		// Drain, then allow for any stray word.
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && awaited_status.size() == 0)
			$display("dmx512_frame_receiver_tb: clean");
		else
			$display("dmx512_frame_receiver_tb: errors");
		$finish;
	end

endmodule
